/* hw/rtl/adh_pkg.sv */
// Package for the advertising data HID parser: payload types, codes and sizes.
package adh_pkg;

  // Name buffer capacity of the device record, terminator included.
  localparam int NAME_CAPACITY = 32;
  localparam logic [7:0] NAME_LIMIT = 8'(NAME_CAPACITY - 1);

  // Depth of the result queue; one item may push up to three results.
  localparam int RESULT_DEPTH = 8;
  localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
  localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);
  localparam int MAX_PUSH = 3;

  // Result kinds.
  localparam logic [1:0] KIND_NAME_BYTE = 2'd0;
  localparam logic [1:0] KIND_NAME_END  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY   = 2'd2;

  // Advertising element types.
  localparam logic [7:0] AD_UUID16_MORE    = 8'h02;
  localparam logic [7:0] AD_UUID16_ALL     = 8'h03;
  localparam logic [7:0] AD_NAME_SHORT     = 8'h08;
  localparam logic [7:0] AD_NAME_COMPLETE  = 8'h09;
  localparam logic [7:0] AD_APPEARANCE     = 8'h19;

  // HID service and appearance values.
  localparam logic [15:0] UUID_HID      = 16'h1812;
  localparam logic [15:0] APP_KEYBOARD  = 16'h03C1;
  localparam logic [15:0] APP_MOUSE     = 16'h03C2;
  localparam logic [15:0] APP_HID_MASK  = 16'hFFC0;
  localparam logic [15:0] APP_HID_BASE  = 16'h03C0;

  // Appearance classes.
  localparam logic [1:0] CLASS_KEYBOARD = 2'd1;
  localparam logic [1:0] CLASS_MOUSE    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_payload;
    logic [7:0] payload_length;
    logic       prior_is_hid;
    logic [1:0] prior_appearance;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [4:0] name_index;
    logic [7:0] name_value;
    logic [4:0] name_length;
    logic       hid_flag;
    logic [1:0] appearance_class;
    logic       last;
  } result_t;

endpackage

/* hw/rtl/adv_data_hid_parser.sv */
// Top level of the advertising data parser that flags HID devices and their class.
//
// The item channel takes one advertising payload byte per request together with
// start_of_payload, the payload length and the record's prior HID flag and
// appearance class. The result channel returns name bytes, a name-end request
// carrying the truncated length, and one summary request (last = 1) on the
// final byte of each payload.
// Each accepted byte is parsed in the cycle it is taken; its results are registered into
// the eight-entry result queue behind any results already waiting there.
// Throughput is one byte per cycle while item_stall is low. The result port drains
// one request per cycle while result_stall is low, so a byte that makes two or three
// results needs as many result requests; item_stall rises while fewer than three
// queue entries are free, which sets the sustained rate for name-heavy payloads.
// When the receiver holds result_stall, the head request stays on the port
// unchanged and the queue fills until item_stall pushes back on the source.
// Synchronous reset empties the queue and clears the parse state; the sticky
// flags load from the prior inputs on every start_of_payload byte.
module adv_data_hid_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  adh_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output adh_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_LEN   = 3'b001,
    PH_TYPE  = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  // Parse state.
  logic [7:0] byte_position, byte_position_next;
  phase_t     parse_phase, parse_phase_next;
  logic [7:0] element_remaining, element_remaining_next;
  logic [7:0] element_type, element_type_next;
  logic [7:0] value_index, value_index_next;
  logic       parse_stopped, parse_stopped_next;
  logic [7:0] held_low_byte, held_low_byte_next;
  logic       hid_seen, hid_seen_next;
  logic [1:0] appearance_seen, appearance_seen_next;

  // Result queue.
  adh_pkg::result_t                 queue [adh_pkg::RESULT_DEPTH];
  logic [adh_pkg::RESULT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [adh_pkg::RESULT_CNT_W-1:0] fill, fill_next;

  logic accept, pop;
  logic push_name_byte, push_name_end, push_summary;
  logic [1:0] push_count;
  adh_pkg::result_t name_byte_res, name_end_res, summary_res;
  adh_pkg::result_t push_res [adh_pkg::MAX_PUSH];

  assign accept       = item_valid && !item_stall;
  assign result_valid = (fill != '0);
  assign pop          = result_valid && !result_stall;
  assign result       = queue[rd_ptr];
  assign item_stall   = (fill > adh_pkg::RESULT_CNT_W'(adh_pkg::RESULT_DEPTH - adh_pkg::MAX_PUSH));

  // Parse one byte. Start of payload clears the state before the byte is used.
  always_comb begin
    logic [8:0]  pos9, len9, sum9;
    logic        is_name;
    logic [15:0] word;
    logic [8:0]  name_len9;

    byte_position_next     = byte_position;
    parse_phase_next       = parse_phase;
    element_remaining_next = element_remaining;
    element_type_next      = element_type;
    value_index_next       = value_index;
    parse_stopped_next     = parse_stopped;
    held_low_byte_next     = held_low_byte;
    hid_seen_next          = hid_seen;
    appearance_seen_next   = appearance_seen;

    if (item.start_of_payload) begin
      byte_position_next     = '0;
      parse_phase_next       = PH_LEN;
      element_remaining_next = '0;
      element_type_next      = '0;
      value_index_next       = '0;
      parse_stopped_next     = 1'b0;
      held_low_byte_next     = '0;
      hid_seen_next          = item.prior_is_hid;
      appearance_seen_next   = item.prior_appearance;
    end

    pos9      = {1'b0, byte_position_next};
    len9      = {1'b0, item.payload_length};
    sum9      = pos9 + 9'd1 + {1'b0, item.data_byte};
    is_name   = (element_type_next == adh_pkg::AD_NAME_SHORT) ||
                (element_type_next == adh_pkg::AD_NAME_COMPLETE);
    word      = {item.data_byte, held_low_byte_next};
    name_len9 = {1'b0, value_index_next} + 9'd1;
    if (name_len9 > {1'b0, adh_pkg::NAME_LIMIT}) begin
      name_len9 = {1'b0, adh_pkg::NAME_LIMIT};
    end

    push_name_byte = 1'b0;
    push_name_end  = 1'b0;
    push_summary   = 1'b0;
    name_byte_res  = '0;
    name_end_res   = '0;
    summary_res    = '0;

    name_byte_res.result_kind = adh_pkg::KIND_NAME_BYTE;
    name_byte_res.name_index  = value_index_next[4:0];
    name_byte_res.name_value  = item.data_byte;
    name_end_res.result_kind  = adh_pkg::KIND_NAME_END;

    // Bytes past the payload leave everything as it is, position included.
    if (pos9 < len9) begin
      if (!parse_stopped_next) begin
        unique case (parse_phase_next)
          PH_LEN: begin
            if ((pos9 + 9'd2 > len9) || (item.data_byte == 8'd0) || (sum9 > len9)) begin
              parse_stopped_next = 1'b1;
            end else begin
              element_remaining_next = item.data_byte;
              parse_phase_next       = PH_TYPE;
            end
          end
          PH_TYPE: begin
            element_type_next      = item.data_byte;
            value_index_next       = '0;
            held_low_byte_next     = '0;
            element_remaining_next = element_remaining_next - 8'd1;
            if (element_remaining_next == 8'd0) begin
              // An empty name element still closes with a zero length.
              push_name_end = (item.data_byte == adh_pkg::AD_NAME_SHORT) ||
                              (item.data_byte == adh_pkg::AD_NAME_COMPLETE);
              name_end_res.name_length = '0;
              parse_phase_next = PH_LEN;
            end else begin
              parse_phase_next = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (is_name) begin
              push_name_byte = (value_index_next < adh_pkg::NAME_LIMIT);
              if (element_remaining_next == 8'd1) begin
                push_name_end            = 1'b1;
                name_end_res.name_length = name_len9[4:0];
              end
            end else if ((element_type_next == adh_pkg::AD_UUID16_MORE) ||
                         (element_type_next == adh_pkg::AD_UUID16_ALL)) begin
              if (!value_index_next[0]) begin
                held_low_byte_next = item.data_byte;
              end else if (word == adh_pkg::UUID_HID) begin
                hid_seen_next = 1'b1;
              end
            end else if (element_type_next == adh_pkg::AD_APPEARANCE) begin
              if (value_index_next == 8'd0) begin
                held_low_byte_next = item.data_byte;
              end else if (value_index_next == 8'd1) begin
                priority if (word == adh_pkg::APP_KEYBOARD) begin
                  hid_seen_next        = 1'b1;
                  appearance_seen_next = adh_pkg::CLASS_KEYBOARD;
                end else if (word == adh_pkg::APP_MOUSE) begin
                  hid_seen_next        = 1'b1;
                  appearance_seen_next = adh_pkg::CLASS_MOUSE;
                end else if ((word & adh_pkg::APP_HID_MASK) == adh_pkg::APP_HID_BASE) begin
                  hid_seen_next = 1'b1;
                end
              end
            end
            if (value_index_next != 8'hFF) begin
              value_index_next = value_index_next + 8'd1;
            end
            element_remaining_next = element_remaining_next - 8'd1;
            if (element_remaining_next == 8'd0) begin
              parse_phase_next = PH_LEN;
            end
          end
          default: begin
            parse_phase_next = PH_LEN;
          end
        endcase
      end

      // The final payload byte always reports the accumulated flags.
      if (pos9 + 9'd1 == len9) begin
        push_summary                 = 1'b1;
        summary_res.result_kind      = adh_pkg::KIND_SUMMARY;
        summary_res.hid_flag         = hid_seen_next;
        summary_res.appearance_class = appearance_seen_next;
        summary_res.last             = 1'b1;
      end

      if (byte_position_next != 8'hFF) begin
        byte_position_next = byte_position_next + 8'd1;
      end
    end

    // Pack the results in order: name byte, name end, summary.
    push_count = 2'({1'b0, push_name_byte} + {1'b0, push_name_end} + {1'b0, push_summary});
    push_res[0] = push_name_byte ? name_byte_res :
                  (push_name_end ? name_end_res : summary_res);
    push_res[1] = (push_name_byte && push_name_end) ? name_end_res : summary_res;
    push_res[2] = summary_res;
  end

  always_comb begin
    fill_next = fill;
    if (accept) begin
      fill_next = fill_next + adh_pkg::RESULT_CNT_W'(push_count);
    end
    if (pop) begin
      fill_next = fill_next - adh_pkg::RESULT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      parse_phase       <= PH_LEN;
      element_remaining <= '0;
      element_type      <= '0;
      value_index       <= '0;
      parse_stopped     <= 1'b0;
      held_low_byte     <= '0;
      hid_seen          <= 1'b0;
      appearance_seen   <= '0;
      wr_ptr            <= '0;
      rd_ptr            <= '0;
      fill              <= '0;
    end else begin
      fill <= fill_next;
      if (pop) begin
        rd_ptr <= rd_ptr + adh_pkg::RESULT_PTR_W'(1);
      end
      if (accept) begin
        byte_position     <= byte_position_next;
        parse_phase       <= parse_phase_next;
        element_remaining <= element_remaining_next;
        element_type      <= element_type_next;
        value_index       <= value_index_next;
        parse_stopped     <= parse_stopped_next;
        held_low_byte     <= held_low_byte_next;
        hid_seen          <= hid_seen_next;
        appearance_seen   <= appearance_seen_next;
        wr_ptr            <= wr_ptr + adh_pkg::RESULT_PTR_W'(push_count);
      end
    end
  end

  // Queue entries need no reset; only filled entries are ever offered.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < adh_pkg::MAX_PUSH; i++) begin
        if (i < int'(push_count)) begin
          queue[wr_ptr + adh_pkg::RESULT_PTR_W'(i)] <= push_res[i];
        end
      end
    end
  end

endmodule

/* tb/sv/adv_data_hid_parser_tb.sv */
// Self-checking testbench for the advertising data HID parser.
module adv_data_hid_parser_tb;
  import adh_pkg::*;

  // Stop requesting random payloads once this many in-payload bytes have gone in.
  localparam int ITEMS = 380;
  // This limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to watch for stray results after the last one owed has arrived.
  localparam int TAIL_CYCLES = 40;

  typedef enum logic [1:0] {WANT_LENGTH, WANT_TYPE, WANT_VALUE} ad_phase_t;

  // One directed row. A typed row carries the single result it must produce.
  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  adv_data_hid_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Parser state mirrored by the testbench. It is updated once for every request the block takes.
  logic [7:0] ps_pos = '0;
  ad_phase_t  ps_phase = WANT_LENGTH;
  logic [7:0] ps_remaining = '0;
  logic [7:0] ps_type = '0;
  logic [7:0] ps_vidx = '0;
  logic       ps_stopped = 1'b0;
  logic [7:0] ps_held = '0;
  logic       ps_hid = 1'b0;
  logic [1:0] ps_class = '0;

  result_t byte_results[$];   // results caused by the byte just parsed
  result_t results_due[$];    // results the block still owes, oldest first
  stim_row_t directed_rows[$];
  logic [7:0] ad_bytes[$];    // payload under construction

  int  errors = 0;
  int  checked = 0;
  int  name_bytes_seen = 0;
  int  hid_summaries = 0;
  int  cycles = 0;
  int  gap_next = 1;
  int  hold_left = 0;
  bit  calm = 1'b0;           // when set, neither side idles

  function automatic result_t make_result(input logic [1:0] kind, input int idx,
                                          input logic [7:0] val, input int nlen,
                                          input logic hid, input logic [1:0] cls,
                                          input logic last);
    result_t r;
    r.result_kind      = kind;
    r.name_index       = 5'(idx);
    r.name_value       = val;
    r.name_length      = 5'(nlen);
    r.hid_flag         = hid;
    r.appearance_class = cls;
    r.last             = last;
    return r;
  endfunction

  function automatic result_t summary_of(input logic hid, input logic [1:0] cls);
    return make_result(KIND_SUMMARY, 0, 8'h00, 0, hid, cls, 1'b1);
  endfunction

  function automatic bit is_name(input logic [7:0] t);
    return t == AD_NAME_SHORT || t == AD_NAME_COMPLETE;
  endfunction

  // Parses one accepted byte and leaves the results it causes in byte_results.
  function automatic void parse_byte(input item_t it);
    int         pos;
    int         len;
    int         vi;
    int         n;
    logic [7:0] b;
    logic [15:0] word;
    b = it.data_byte;
    len = int'(it.payload_length);
    byte_results.delete();
    // A new payload clears the parse and loads the sticky flags from the record.
    if (it.start_of_payload) begin
      ps_pos = '0;
      ps_phase = WANT_LENGTH;
      ps_remaining = '0;
      ps_type = '0;
      ps_vidx = '0;
      ps_stopped = 1'b0;
      ps_held = '0;
      ps_hid = it.prior_is_hid;
      ps_class = it.prior_appearance;
    end
    pos = int'(ps_pos);
    // A byte beyond the payload is dropped without any effect.
    if (pos >= len) return;
    if (!ps_stopped) begin
      case (ps_phase)
        WANT_LENGTH: begin
          // The parse stops at a zero length, a trailing lone length byte, or an overrun.
          if (pos + 2 > len || b == 8'h00 || pos + 1 + int'(b) > len) begin
            ps_stopped = 1'b1;
          end else begin
            ps_remaining = b;
            ps_phase = WANT_TYPE;
          end
        end
        WANT_TYPE: begin
          ps_type = b;
          ps_vidx = '0;
          ps_held = '0;
          ps_remaining = ps_remaining - 8'd1;
          if (ps_remaining == 8'd0) begin
            if (is_name(b)) byte_results.push_back(make_result(KIND_NAME_END, 0, 8'h00, 0,
                                                               1'b0, 2'd0, 1'b0));
            ps_phase = WANT_LENGTH;
          end else begin
            ps_phase = WANT_VALUE;
          end
        end
        default: begin
          vi = int'(ps_vidx);
          word = {b, ps_held};
          if (is_name(ps_type)) begin
            if (vi < NAME_CAPACITY - 1)
              byte_results.push_back(make_result(KIND_NAME_BYTE, vi, b, 0, 1'b0, 2'd0, 1'b0));
            if (ps_remaining == 8'd1) begin
              n = (vi + 1 > NAME_CAPACITY - 1) ? NAME_CAPACITY - 1 : vi + 1;
              byte_results.push_back(make_result(KIND_NAME_END, 0, 8'h00, n, 1'b0, 2'd0, 1'b0));
            end
          end else if (ps_type == AD_UUID16_MORE || ps_type == AD_UUID16_ALL) begin
            // UUIDs are little-endian pairs. An odd last byte is only held and never used.
            if (vi % 2 == 0) ps_held = b;
            else if (word == UUID_HID) ps_hid = 1'b1;
          end else if (ps_type == AD_APPEARANCE) begin
            if (vi == 0) begin
              ps_held = b;
            end else if (vi == 1) begin
              if (word == APP_KEYBOARD) begin
                ps_hid = 1'b1;
                ps_class = CLASS_KEYBOARD;
              end else if (word == APP_MOUSE) begin
                ps_hid = 1'b1;
                ps_class = CLASS_MOUSE;
              end else if ((word & APP_HID_MASK) == APP_HID_BASE) begin
                ps_hid = 1'b1;
              end
            end
          end
          if (ps_vidx != 8'hFF) ps_vidx = ps_vidx + 8'd1;
          ps_remaining = ps_remaining - 8'd1;
          if (ps_remaining == 8'd0) ps_phase = WANT_LENGTH;
        end
      endcase
    end
    if (pos + 1 == len) byte_results.push_back(summary_of(ps_hid, ps_class));
    if (ps_pos != 8'hFF) ps_pos = ps_pos + 8'd1;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d idx=%0d val=%02h len=%0d hid=%0d class=%0d last=%0d",
                     r.result_kind, r.name_index, r.name_value, r.name_length,
                     r.hid_flag, r.appearance_class, r.last);
  endfunction

  function automatic void add_row(input logic [7:0] data, input logic sop,
                                  input logic [7:0] len, input logic hid,
                                  input logic [1:0] cls, input logic typed,
                                  input result_t want);
    stim_row_t row;
    row.it.data_byte = data;
    row.it.start_of_payload = sop;
    row.it.payload_length = len;
    row.it.prior_is_hid = hid;
    row.it.prior_appearance = cls;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Sends one request. Valid stays high into the next request when that one has no gap,
  // so valid never gets two assignments in the same step.
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    if (gap_next != 0) repeat (gap_next) @(posedge clk);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    parse_byte(it);
    if (typed) results_due.push_back(want);
    else foreach (byte_results[k]) results_due.push_back(byte_results[k]);
    gap_next = draw_wait();
    if (gap_next != 0) item_valid <= 1'b0;
  endtask

  // Lowers valid in the step of the last acceptance. Call it before the source pauses.
  task automatic hold_off();
    if (gap_next == 0) begin
      item_valid <= 1'b0;
      gap_next = 1;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    checked++;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= 40) $display("%0t: result with none owed: %s", $time, fmt_result(got));
      return;
    end
    want = results_due.pop_front();
    if (want.result_kind == KIND_NAME_BYTE) name_bytes_seen++;
    if (want.result_kind == KIND_SUMMARY && want.hid_flag) hid_summaries++;
    if (got.result_kind !== want.result_kind || got.name_index !== want.name_index ||
        got.name_value !== want.name_value || got.name_length !== want.name_length ||
        got.hid_flag !== want.hid_flag || got.appearance_class !== want.appearance_class ||
        got.last !== want.last) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result mismatch: expected %s, actual %s", $time, fmt_result(want),
                 fmt_result(got));
    end
  endtask

  // Result side. Each accepted request is checked, and then a fresh stall length is drawn.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
    end else if (result_valid && !result_stall) begin
      check_result(result);
      hold_left = draw_wait();
      result_stall <= (hold_left != 0);
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results owed", $time, results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    item_t it;
    int    declared;
    int    count;
    int    change_at;
    int    new_len;
    int    i;
    int    kind;
    int    vlen;
    int    target;
    int    sent = 0;
    int    payloads = 0;
    int    pauses = 0;
    logic [7:0]  etype;
    logic [15:0] word;
    bit    exact;
    bit    change_len;
    bit    long_pending = 1'b1;
    result_t none;
    none = '0;

    // Directed rows: single-byte payloads, dropped bytes, an empty name, mouse and HID-range
    // appearances, an odd UUID list and a mid-payload length change.
    add_row(8'hFF, 1'b1, 8'd1, 1'b1, CLASS_MOUSE, 1'b1, summary_of(1'b1, CLASS_MOUSE));
    add_row(8'h00, 1'b1, 8'd1, 1'b0, 2'd3, 1'b1, summary_of(1'b0, 2'd3));
    add_row(8'h55, 1'b0, 8'd1, 1'b0, 2'd0, 1'b0, none);  // past the end of the payload
    add_row(8'hAA, 1'b1, 8'd0, 1'b1, 2'd1, 1'b0, none);  // zero payload length
    // Empty name, mouse appearance, then a one-byte appearance value.
    add_row(8'h01, 1'b1, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(AD_NAME_COMPLETE, 1'b0, 8'd9, 1'b0, 2'd0, 1'b1,
            make_result(KIND_NAME_END, 0, 8'h00, 0, 1'b0, 2'd0, 1'b0));
    add_row(8'h03, 1'b0, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(AD_APPEARANCE, 1'b0, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(APP_MOUSE[7:0], 1'b0, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(APP_MOUSE[15:8], 1'b0, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(8'h02, 1'b0, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(AD_APPEARANCE, 1'b0, 8'd9, 1'b0, 2'd0, 1'b0, none);
    add_row(APP_KEYBOARD[7:0], 1'b0, 8'd9, 1'b0, 2'd0, 1'b1, summary_of(1'b1, CLASS_MOUSE));
    // An appearance in the HID range that is neither keyboard nor mouse.
    add_row(8'h03, 1'b1, 8'd4, 1'b0, 2'd0, 1'b0, none);
    add_row(AD_APPEARANCE, 1'b0, 8'd4, 1'b0, 2'd0, 1'b0, none);
    add_row(8'hC5, 1'b0, 8'd4, 1'b0, 2'd0, 1'b0, none);
    add_row(8'h03, 1'b0, 8'd4, 1'b0, 2'd0, 1'b1, summary_of(1'b1, 2'd0));
    // A UUID list with the HID service and an unpaired trailing byte.
    add_row(8'h04, 1'b1, 8'd5, 1'b0, CLASS_KEYBOARD, 1'b0, none);
    add_row(AD_UUID16_ALL, 1'b0, 8'd5, 1'b0, 2'd0, 1'b0, none);
    add_row(UUID_HID[7:0], 1'b0, 8'd5, 1'b0, 2'd0, 1'b0, none);
    add_row(UUID_HID[15:8], 1'b0, 8'd5, 1'b0, 2'd0, 1'b0, none);
    add_row(8'h77, 1'b0, 8'd5, 1'b0, 2'd0, 1'b1, summary_of(1'b1, CLASS_KEYBOARD));
    // A short name whose payload length shrinks on the last byte.
    add_row(8'h03, 1'b1, 8'd6, 1'b1, 2'd0, 1'b0, none);
    add_row(AD_NAME_SHORT, 1'b0, 8'd6, 1'b0, 2'd0, 1'b0, none);
    add_row(8'h48, 1'b0, 8'd6, 1'b0, 2'd0, 1'b0, none);
    add_row(8'h69, 1'b0, 8'd4, 1'b0, 2'd0, 1'b0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].it.start_of_payload) payloads++;
      send_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);
    end

    // Let everything drain once before the random part starts.
    hold_off();
    while (results_due.size() != 0) @(posedge clk);
    pauses++;

    while (sent < ITEMS) begin
      // Build a payload that is mostly well-formed elements with random content.
      ad_bytes.delete();
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      exact = 1'($urandom_range(0, 1));
      while (ad_bytes.size() < target) begin
        kind = $urandom_range(0, 15);
        if (kind <= 4) begin
          etype = $urandom_range(0, 1) ? AD_NAME_SHORT : AD_NAME_COMPLETE;
          vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
          ad_bytes.push_back(8'(vlen + 1));
          ad_bytes.push_back(etype);
          repeat (vlen) ad_bytes.push_back(8'($urandom));
        end else if (kind <= 7) begin
          etype = $urandom_range(0, 1) ? AD_UUID16_MORE : AD_UUID16_ALL;
          vlen = $urandom_range(0, 7);
          ad_bytes.push_back(8'(vlen + 1));
          ad_bytes.push_back(etype);
          for (i = 0; i < vlen; i += 2) begin
            word = ($urandom_range(0, 2) == 0) ? UUID_HID : 16'($urandom);
            ad_bytes.push_back(word[7:0]);
            if (i + 1 < vlen) ad_bytes.push_back(word[15:8]);
          end
        end else if (kind <= 10) begin
          vlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 2;
          case ($urandom_range(0, 3))
            0: word = APP_KEYBOARD;
            1: word = APP_MOUSE;
            2: word = APP_HID_BASE | 16'($urandom_range(0, 63));
            default: word = 16'($urandom);
          endcase
          ad_bytes.push_back(8'(vlen + 1));
          ad_bytes.push_back(AD_APPEARANCE);
          for (i = 0; i < vlen; i++)
            ad_bytes.push_back(i == 0 ? word[7:0] : (i == 1 ? word[15:8] : 8'($urandom)));
        end else if (kind <= 13) begin
          vlen = $urandom_range(0, 4);
          ad_bytes.push_back(8'(vlen + 1));
          ad_bytes.push_back(8'($urandom));
          repeat (vlen) ad_bytes.push_back(8'($urandom));
        end else if (kind == 14) begin
          ad_bytes.push_back(8'h00);
        end else begin
          ad_bytes.push_back(8'($urandom));
        end
      end
      // Either end on an element boundary or cut the last element short.
      count = exact ? ad_bytes.size() : target;
      if (count > 255) count = 255;
      while (ad_bytes.size() > count) void'(ad_bytes.pop_back());
      declared = count;
      // Sometimes the payload is left unfinished under a larger declared length, once at 255.
      if (count < 255 && (long_pending || $urandom_range(0, 11) == 0)) begin
        declared = long_pending ? 255 : $urandom_range(count + 1, 255);
        long_pending = 1'b0;
      end
      change_len = ($urandom_range(0, 19) == 0);
      change_at = $urandom_range(0, count - 1);
      new_len = $urandom_range(1, 255);
      if ($urandom_range(0, 3) == 0) calm = !calm;

      payloads++;
      for (i = 0; i < count; i++) begin
        it.data_byte = ad_bytes[i];
        it.start_of_payload = (i == 0);
        it.payload_length = (change_len && i >= change_at) ? 8'(new_len) : 8'(declared);
        it.prior_is_hid = 1'($urandom_range(0, 1));
        it.prior_appearance = 2'($urandom_range(0, 2));
        send_item(it, 1'b0, none);
        sent++;
      end
      // Stray bytes after the payload, which are dropped if the payload is complete.
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          it.data_byte = 8'($urandom);
          it.start_of_payload = 1'b0;
          it.payload_length = 8'(declared);
          it.prior_is_hid = 1'($urandom_range(0, 1));
          it.prior_appearance = 2'($urandom_range(0, 2));
          send_item(it, 1'b0, none);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        hold_off();
        while (results_due.size() != 0) @(posedge clk);
        pauses++;
      end
    end

    hold_off();
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d payloads with %0d directed and %0d random bytes, %0d drain pauses.",
             payloads, directed_rows.size(), sent, pauses);
    $display("Checked %0d results: %0d name bytes, %0d summaries with HID set, %0d errors.",
             checked, name_bytes_seen, hid_summaries, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/adh_pkg.sv
hw/rtl/adv_data_hid_parser.sv
tb/sv/adv_data_hid_parser_tb.sv
